// File: hdl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/lcdnb_pkg.sv
package lcdnb_pkg;

    localparam int STEP_W = 5;

    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_INSTR = 2'd1;
    localparam logic [1:0] ACT_POWER = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] CFG_BYTE_GAP   = 2'd0;
    localparam logic [1:0] CFG_WAIT_SHORT = 2'd1;
    localparam logic [1:0] CFG_WAIT_LONG  = 2'd2;

    localparam logic [7:0] BYTE_GAP_RST   = 8'd1;
    localparam logic [7:0] WAIT_SHORT_RST = 8'd5;
    localparam logic [7:0] WAIT_LONG_RST  = 8'd100;

    localparam logic [2:0] OP_SHOW  = 3'd0;
    localparam logic [2:0] OP_EN_HI = 3'd1;
    localparam logic [2:0] OP_NIB   = 3'd2;
    localparam logic [2:0] OP_EN_LO = 3'd3;
    localparam logic [2:0] OP_RS_LO = 3'd4;
    localparam logic [2:0] OP_RS_HI = 3'd5;
    localparam logic [2:0] OP_ZERO  = 3'd6;

    localparam logic [3:0] NIB_INIT   = 4'h3;
    localparam logic [3:0] NIB_FUNC   = 4'h2;
    localparam logic [7:0] CLEAR_CMD  = 8'h01;

    localparam logic [STEP_W-1:0] DATA_LAST_STEP  = 5'd6;
    localparam logic [STEP_W-1:0] INSTR_LAST_STEP = 5'd7;
    localparam logic [STEP_W-1:0] PWR_INIT_END    = 5'd12;
    localparam logic [STEP_W-1:0] PWR_RS_STEP     = 5'd13;
    localparam logic [STEP_W-1:0] PWR_CLEAR_START = 5'd14;
    localparam logic [STEP_W-1:0] PWR_LAST_STEP   = 5'd21;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] nib;
        logic [7:0] hold;
        logic       last;
    } op_t;

endpackage

// File: hdl/lcdnb_step.sv
module lcdnb_step (
    input  logic [1:0]                 action,
    input  logic [7:0]                 value,
    input  logic [lcdnb_pkg::STEP_W-1:0] step,
    input  logic [7:0]                 byte_gap_ms,
    input  logic [7:0]                 power_wait_short_ms,
    input  logic [7:0]                 power_wait_long_ms,
    output lcdnb_pkg::op_t             op
);

    function automatic lcdnb_pkg::op_t byte_op(
        input logic [2:0] idx,
        input logic [7:0] b,
        input logic [2:0] first_kind,
        input logic [7:0] gap
    );
        lcdnb_pkg::op_t r;
        r = '{kind: lcdnb_pkg::OP_SHOW, nib: 4'd0, hold: 8'd0, last: 1'b0};
        unique case (idx)
            3'd0:
            begin
                r.kind = first_kind;
                r.hold = gap;
            end
            3'd1: r.kind = lcdnb_pkg::OP_EN_HI;
            3'd2:
            begin
                r.kind = lcdnb_pkg::OP_NIB;
                r.nib  = b[7:4];
            end
            3'd3: r.kind = lcdnb_pkg::OP_EN_LO;
            3'd4: r.kind = lcdnb_pkg::OP_EN_HI;
            3'd5:
            begin
                r.kind = lcdnb_pkg::OP_NIB;
                r.nib  = b[3:0];
            end
            3'd6:
            begin
                r.kind = lcdnb_pkg::OP_EN_LO;
                r.hold = gap;
            end
            3'd7: r.kind = lcdnb_pkg::OP_RS_HI;
        endcase
        return r;
    endfunction

    logic [lcdnb_pkg::STEP_W-1:0] clear_idx;

    assign clear_idx = step - lcdnb_pkg::PWR_CLEAR_START;

    always_comb
    begin
        op = '{kind: lcdnb_pkg::OP_SHOW, nib: 4'd0, hold: 8'd0, last: 1'b0};
        unique case (action)
            lcdnb_pkg::ACT_DATA:
            begin
                op = byte_op(step[2:0], value, lcdnb_pkg::OP_SHOW, byte_gap_ms);
                op.last = (step == lcdnb_pkg::DATA_LAST_STEP);
            end
            lcdnb_pkg::ACT_INSTR:
            begin
                op = byte_op(step[2:0], value, lcdnb_pkg::OP_RS_LO, byte_gap_ms);
                op.last = (step == lcdnb_pkg::INSTR_LAST_STEP);
            end
            lcdnb_pkg::ACT_POWER:
            begin
                if (step == '0)
                begin
                    op.kind = lcdnb_pkg::OP_ZERO;
                end
                else if (step <= lcdnb_pkg::PWR_INIT_END)
                begin
                    unique case (step)
                        5'd1, 5'd4, 5'd7, 5'd10: op.kind = lcdnb_pkg::OP_EN_HI;
                        5'd2, 5'd5, 5'd8:
                        begin
                            op.kind = lcdnb_pkg::OP_NIB;
                            op.nib  = lcdnb_pkg::NIB_INIT;
                        end
                        5'd11:
                        begin
                            op.kind = lcdnb_pkg::OP_NIB;
                            op.nib  = lcdnb_pkg::NIB_FUNC;
                        end
                        5'd3, 5'd12:
                        begin
                            op.kind = lcdnb_pkg::OP_EN_LO;
                            op.hold = power_wait_short_ms;
                        end
                        5'd6, 5'd9:
                        begin
                            op.kind = lcdnb_pkg::OP_EN_LO;
                            op.hold = power_wait_long_ms;
                        end
                        default: op.kind = lcdnb_pkg::OP_SHOW;
                    endcase
                end
                else if (step == lcdnb_pkg::PWR_RS_STEP)
                begin
                    op.kind = lcdnb_pkg::OP_RS_HI;
                end
                else
                begin
                    op = byte_op(clear_idx[2:0], lcdnb_pkg::CLEAR_CMD,
                                 lcdnb_pkg::OP_RS_LO, byte_gap_ms);
                    op.last = (step == lcdnb_pkg::PWR_LAST_STEP);
                end
            end
            default: op.last = 1'b1;
        endcase
    end

endmodule

// File: hdl/lcd_nibble_bus_sequencer_core.sv
// An accepted item is taken into the item registers; its pin states then go to the output
// register, one per cycle while that register is empty or being read. A data byte is 7 steps,
// an instruction 8, power-up 22, walked by the single sequencer's step counter; the next item is
// taken in the cycle the current one loads its last pin state. Action 3 is taken and dropped.
// Reset (rst_n low, asynchronous): pins low, sequencer idle, registers to 1, 5, 100 ms.
module lcd_nibble_bus_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] data_nibble, [4] enable, [12:5] hold_ms, zero pad
    output logic        m_tuser,   // [0] reg_select
    output logic        m_tlast
);

    logic [7:0] gap_reg, gap_next;
    logic [7:0] wshort_reg, wshort_next;
    logic [7:0] wlong_reg, wlong_next;

    logic                         cur_valid_reg, cur_valid_next;
    logic [1:0]                   action_reg, action_next;
    logic [7:0]                   value_reg, value_next;
    logic [lcdnb_pkg::STEP_W-1:0] step_reg, step_next;

    logic [3:0] nib_reg, nib_next;
    logic       rs_reg, rs_next;
    logic       en_reg, en_next;

    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_nib_reg, out_nib_next;
    logic       out_rs_reg, out_rs_next;
    logic       out_en_reg, out_en_next;
    logic [7:0] out_hold_reg, out_hold_next;
    logic       out_last_reg, out_last_next;

    lcdnb_pkg::op_t op;
    logic           advance;
    logic           accept;

    lcdnb_step u_step (
        .action              (action_reg),
        .value               (value_reg),
        .step                (step_reg),
        .byte_gap_ms         (gap_reg),
        .power_wait_short_ms (wshort_reg),
        .power_wait_long_ms  (wlong_reg),
        .op                  (op)
    );

    assign advance  = cur_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !cur_valid_reg || (advance && op.last);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        gap_next    = gap_reg;
        wshort_next = wshort_reg;
        wlong_next  = wlong_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lcdnb_pkg::CFG_BYTE_GAP:   gap_next    = cfg_data;
                lcdnb_pkg::CFG_WAIT_SHORT: wshort_next = cfg_data;
                lcdnb_pkg::CFG_WAIT_LONG:  wlong_next  = cfg_data;
                default:                   gap_next    = gap_reg;
            endcase
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        action_next    = action_reg;
        value_next     = value_reg;
        step_next      = step_reg;
        nib_next       = nib_reg;
        rs_next        = rs_reg;
        en_next        = en_reg;

        if (advance)
        begin
            step_next = step_reg + 1'b1;
            if (op.last)
            begin
                cur_valid_next = 1'b0;
            end
            unique case (op.kind)
                lcdnb_pkg::OP_ZERO:
                begin
                    nib_next = 4'd0;
                    rs_next  = 1'b0;
                    en_next  = 1'b0;
                end
                lcdnb_pkg::OP_EN_HI: en_next  = 1'b1;
                lcdnb_pkg::OP_EN_LO: en_next  = 1'b0;
                lcdnb_pkg::OP_NIB:   nib_next = op.nib;
                lcdnb_pkg::OP_RS_LO: rs_next  = 1'b0;
                lcdnb_pkg::OP_RS_HI: rs_next  = 1'b1;
                default:             en_next  = en_reg;
            endcase
        end

        if (accept)
        begin
            action_next    = s_tuser;
            value_next     = s_tdata;
            step_next      = '0;
            cur_valid_next = (s_tuser != lcdnb_pkg::ACT_NONE);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_nib_next   = out_nib_reg;
        out_rs_next    = out_rs_reg;
        out_en_next    = out_en_reg;
        out_hold_next  = out_hold_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_nib_next   = nib_next;
            out_rs_next    = rs_next;
            out_en_next    = en_next;
            out_hold_next  = op.hold;
            out_last_next  = op.last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= lcdnb_pkg::BYTE_GAP_RST;
            wshort_reg    <= lcdnb_pkg::WAIT_SHORT_RST;
            wlong_reg     <= lcdnb_pkg::WAIT_LONG_RST;
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            action_reg    <= lcdnb_pkg::ACT_NONE;
            nib_reg       <= 4'd0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gap_reg       <= gap_next;
            wshort_reg    <= wshort_next;
            wlong_reg     <= wlong_next;
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            action_reg    <= action_next;
            nib_reg       <= nib_next;
            rs_reg        <= rs_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        out_nib_reg  <= out_nib_next;
        out_rs_reg   <= out_rs_next;
        out_en_reg   <= out_en_next;
        out_hold_reg <= out_hold_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_hold_reg, out_en_reg, out_nib_reg};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/lcdnb_checker.sv
`include "assert_macros.svh"

module lcdnb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Stalled item stays put.
    `ASSERT_NEXT(a_out_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_hold_data, clk, rst_n, m_tvalid && !m_tready,
                 $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // Mid-run with a stalled output: no new item.
    `ASSERT_IMPLY(a_no_take_mid_run, clk, rst_n, m_tvalid && !m_tlast && !m_tready, !s_tready)
    // E high states carry zero hold; a run ends with E low.
    `ASSERT_IMPLY(a_strobe_no_hold, clk, rst_n, m_tvalid && m_tdata[4], m_tdata[12:5] == 8'd0)
    `ASSERT_IMPLY(a_last_strobe_low, clk, rst_n, m_tvalid && m_tlast, !m_tdata[4])

endmodule

bind lcd_nibble_bus_sequencer_core lcdnb_checker u_lcdnb_checker (.*);

// File: bench/tb_lcd_nibble_bus_sequencer_core.sv
module tb_lcd_nibble_bus_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] nib;
        logic       rs;
        logic       en;
        logic [7:0] hold;
        logic       last;
    } pin_state_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] value
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [3:0] data_nibble, [4] enable, [12:5] hold_ms, zero pad
    logic        m_tuser;   // [0] reg_select
    logic        m_tlast;

    lcd_nibble_bus_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predictor state and timing copies
    logic [3:0] lcd_nib;
    logic       lcd_rs;
    logic       lcd_en;
    logic [7:0] gap_ms;
    logic [7:0] short_ms;
    logic [7:0] long_ms;

    pin_state_t pins_due[$];
    pin_state_t pending_pin;
    bit         pending_ok;
    pin_state_t want_pin;

    int  mismatches;
    int  burst_left;
    bit  offering;
    int  holdoff_left;
    int  rx_mode;
    int  rx_mode_left;
    int  rx_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- predictor ----------------

    task automatic pin_emit(input logic [7:0] hold);
        if (pending_ok)
            pins_due.push_back(pending_pin);
        pending_pin.nib  = lcd_nib;
        pending_pin.rs   = lcd_rs;
        pending_pin.en   = lcd_en;
        pending_pin.hold = hold;
        pending_pin.last = 1'b0;
        pending_ok = 1'b1;
    endtask

    task automatic pin_nibble_write(input logic [3:0] nib, input logic [7:0] hold_after);
        lcd_en = 1'b1;
        pin_emit(8'd0);
        lcd_nib = nib;
        pin_emit(8'd0);
        lcd_en = 1'b0;
        pin_emit(hold_after);
    endtask

    task automatic pin_byte_write(input logic [7:0] b);
        pin_nibble_write(b[7:4], 8'd0);
        pin_nibble_write(b[3:0], gap_ms);
    endtask

    task automatic pin_instr_write(input logic [7:0] b);
        lcd_rs = 1'b0;
        pin_emit(gap_ms);
        pin_byte_write(b);
        lcd_rs = 1'b1;
        pin_emit(8'd0);
    endtask

    task automatic predict_pin_states(input logic [1:0] action, input logic [7:0] value);
        pending_ok = 1'b0;
        case (action)
            lcdnb_pkg::ACT_DATA:
            begin
                pin_emit(gap_ms);
                pin_byte_write(value);
            end
            lcdnb_pkg::ACT_INSTR:
                pin_instr_write(value);
            lcdnb_pkg::ACT_POWER:
            begin
                lcd_nib = 4'h0;
                lcd_rs  = 1'b0;
                lcd_en  = 1'b0;
                pin_emit(8'd0);
                pin_nibble_write(lcdnb_pkg::NIB_INIT, short_ms);
                pin_nibble_write(lcdnb_pkg::NIB_INIT, long_ms);
                pin_nibble_write(lcdnb_pkg::NIB_INIT, long_ms);
                pin_nibble_write(lcdnb_pkg::NIB_FUNC, short_ms);
                lcd_rs = 1'b1;
                pin_emit(8'd0);
                pin_instr_write(lcdnb_pkg::CLEAR_CMD);
            end
            default:
            begin
            end
        endcase
        if (pending_ok)
        begin
            pending_pin.last = 1'b1;
            pins_due.push_back(pending_pin);
        end
    endtask

    // ---------------- checking ----------------

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pins_due.size() == 0)
            begin
                $display("%0t ns: pin state expected none actual nib %0d en %0d hold %0d",
                         $time, m_tdata[3:0], m_tdata[4], m_tdata[12:5]);
                mismatches++;
            end
            else
            begin
                want_pin = pins_due.pop_front();
                check_field("data_nibble", int'(want_pin.nib), int'(m_tdata[3:0]));
                check_field("enable", int'(want_pin.en), int'(m_tdata[4]));
                check_field("hold_ms", int'(want_pin.hold), int'(m_tdata[12:5]));
                check_field("reg_select", int'(want_pin.rs), int'(m_tuser));
                check_field("last", int'(want_pin.last), int'(m_tlast));
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk)
    begin
        rx_count++;
        if (rx_mode_left <= 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(10, 80);
        end
        rx_mode_left--;
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_count % 4) == 0;
                default: m_tready <= ((rx_count / 4) % 2) == 0;
            endcase
        end
    end

    // ---------------- sender and config ----------------

    task automatic send_item(input logic [1:0] action, input logic [7:0] value);
        if (!offering)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= value;
        offering = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pin_states(action, value);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic wait_idle();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_timing(input logic [7:0] gap, input logic [7:0] shrt,
                              input logic [7:0] lng);
        cfg_we    <= 1'b1;
        cfg_index <= lcdnb_pkg::CFG_BYTE_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= lcdnb_pkg::CFG_WAIT_SHORT;
        cfg_data  <= shrt;
        @(posedge clk);
        cfg_index <= lcdnb_pkg::CFG_WAIT_LONG;
        cfg_data  <= lng;
        @(posedge clk);
        cfg_we <= 1'b0;
        gap_ms   = gap;
        short_ms = shrt;
        long_ms  = lng;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_timing();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return lcdnb_pkg::ACT_DATA;
        else if (r < 85)
            return lcdnb_pkg::ACT_INSTR;
        else if (r < 95)
            return lcdnb_pkg::ACT_POWER;
        else
            return lcdnb_pkg::ACT_NONE;
    endfunction

    // ---------------- tests ----------------

    task automatic test_before_power_up();
        send_item(lcdnb_pkg::ACT_DATA, 8'h00);
        send_item(lcdnb_pkg::ACT_DATA, 8'hFF);
        send_item(lcdnb_pkg::ACT_INSTR, 8'h3C);
        wait_idle();
    endtask

    task automatic test_power_up_and_bytes();
        send_item(lcdnb_pkg::ACT_POWER, 8'($urandom_range(0, 255)));
        send_item(lcdnb_pkg::ACT_DATA, 8'hA5);
        send_item(lcdnb_pkg::ACT_DATA, 8'h5A);
        send_item(lcdnb_pkg::ACT_INSTR, 8'h80);
        send_item(lcdnb_pkg::ACT_INSTR, 8'h0F);
        send_item(lcdnb_pkg::ACT_NONE, 8'hFF);
        send_item(lcdnb_pkg::ACT_NONE, 8'h00);
        send_item(lcdnb_pkg::ACT_DATA, 8'hFF);
        wait_idle();
    endtask

    task automatic test_timing_extremes();
        set_timing(8'd0, 8'd0, 8'd0);
        send_item(lcdnb_pkg::ACT_POWER, 8'h00);
        send_item(lcdnb_pkg::ACT_DATA, 8'h81);
        send_item(lcdnb_pkg::ACT_INSTR, 8'h00);
        wait_idle();
        set_timing(8'd255, 8'd255, 8'd255);
        send_item(lcdnb_pkg::ACT_POWER, 8'hFF);
        send_item(lcdnb_pkg::ACT_INSTR, 8'hFF);
        send_item(lcdnb_pkg::ACT_DATA, 8'h7E);
        wait_idle();
        set_timing(8'd255, 8'd0, 8'd255);
        send_item(lcdnb_pkg::ACT_POWER, 8'h55);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        holdoff_left = 400;
        repeat (25)
            send_item(pick_action(), 8'($urandom_range(0, 255)));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        repeat (4)
        begin
            set_timing(pick_timing(), pick_timing(), pick_timing());
            repeat (45)
                send_item(pick_action(), 8'($urandom_range(0, 255)));
            wait_idle();
        end
    endtask

    initial
    begin
        mismatches   = 0;
        burst_left   = 3;
        offering     = 1'b0;
        holdoff_left = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_count     = 0;
        lcd_nib      = 4'h0;
        lcd_rs       = 1'b0;
        lcd_en       = 1'b0;
        gap_ms       = lcdnb_pkg::BYTE_GAP_RST;
        short_ms     = lcdnb_pkg::WAIT_SHORT_RST;
        long_ms      = lcdnb_pkg::WAIT_LONG_RST;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lcdnb_pkg::CFG_BYTE_GAP;
        cfg_data  <= 8'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= lcdnb_pkg::ACT_DATA;
        m_tready  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_power_up();
        test_power_up_and_bytes();
        test_timing_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pins_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
